### sv/lcvm_pkg.sv
// ---------------------------------------------------------------------------
// lcvm_pkg
// Shared types and constants of the segment clipper with viewport mapping.
// ---------------------------------------------------------------------------
package lcvm_pkg;

  localparam int CoordBits  = 16;
  localparam int DiffBits   = CoordBits + 1;
  localparam int CfgIdxBits = 3;
  localparam int NumEdges   = 4;
  localparam int NumPoints  = 4;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxBits-1:0] CFG_WIN_X_MIN  = 3'd0;
  localparam logic [CfgIdxBits-1:0] CFG_WIN_Y_MIN  = 3'd1;
  localparam logic [CfgIdxBits-1:0] CFG_WIN_X_MAX  = 3'd2;
  localparam logic [CfgIdxBits-1:0] CFG_WIN_Y_MAX  = 3'd3;
  localparam logic [CfgIdxBits-1:0] CFG_VIEW_X_MIN = 3'd4;
  localparam logic [CfgIdxBits-1:0] CFG_VIEW_Y_MIN = 3'd5;
  localparam logic [CfgIdxBits-1:0] CFG_VIEW_X_MAX = 3'd6;
  localparam logic [CfgIdxBits-1:0] CFG_VIEW_Y_MAX = 3'd7;

  typedef logic signed [CoordBits-1:0] coord_t;

  localparam coord_t EdgeMinRst = CoordBits'(0);
  localparam coord_t EdgeMaxRst = CoordBits'(8000);

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } seg_in_t;

  typedef struct packed {
    logic   visible;
    coord_t out_start_x;
    coord_t out_start_y;
    coord_t out_end_x;
    coord_t out_end_y;
  } seg_out_t;

  typedef struct packed {
    coord_t win_x_min;
    coord_t win_y_min;
    coord_t win_x_max;
    coord_t win_y_max;
    coord_t view_x_min;
    coord_t view_y_min;
    coord_t view_x_max;
    coord_t view_y_max;
  } clip_cfg_t;

  // One window edge in sign/magnitude form: t = q / p.
  typedef struct packed {
    logic                pzero;
    logic                pneg;
    logic                qneg;
    logic [DiffBits-1:0] pmag;
    logic [DiffBits-1:0] qmag;
  } edge_cls_t;

  typedef struct packed {
    coord_t                      x0;
    coord_t                      y0;
    logic signed [DiffBits-1:0]  dx;
    logic signed [DiffBits-1:0]  dy;
    logic                        win_ok;
    edge_cls_t [NumEdges-1:0]    edges;
  } seg_cls_t;

endpackage

### sv/line_clip_viewport_map.sv
// ---------------------------------------------------------------------------
// line_clip_viewport_map
// Liang-Barsky segment clipper with window-to-viewport mapping.
// ---------------------------------------------------------------------------
// Segments arrive on the in_ channel (valid/ready) as two Q12.4 endpoints.
// Each segment gives exactly one result on the out_ channel: a visible flag
// and the clipped endpoints mapped into the viewport, rounded to nearest and
// saturated. Invisible segments carry zero coordinates.
// Window and viewport are set through the cfg_ write port (index 0..7) and
// must only change while no segment is in flight.
// Throughput is one segment per cycle while out_ready stays high. From the
// in_ transfer the result passes one front register, the queue, a divider
// with one quotient bit per stage for the edge parameters, four stages for
// the test, clip point, offset and product, then a second divider of 18
// stages for the viewport scale and the output register.
// When the receiver stalls, the back pipeline holds and the four-entry queue
// fills before in_ready falls. Reset empties the pipeline and loads the
// default window and viewport of 0..8000 on both axes.
// ---------------------------------------------------------------------------
module line_clip_viewport_map #(
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lcvm_pkg::seg_in_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lcvm_pkg::seg_out_t                  out_data,
  input  logic                                cfg_we,
  input  logic [lcvm_pkg::CfgIdxBits-1:0]     cfg_idx,
  input  logic [lcvm_pkg::CoordBits-1:0]      cfg_wdata
);
  import lcvm_pkg::*;

  clip_cfg_t cfg_r;
  seg_cls_t  fq_data, qb_data;
  logic      fq_valid, fq_ready, qb_valid, qb_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.win_x_min  <= EdgeMinRst;
      cfg_r.win_y_min  <= EdgeMinRst;
      cfg_r.win_x_max  <= EdgeMaxRst;
      cfg_r.win_y_max  <= EdgeMaxRst;
      cfg_r.view_x_min <= EdgeMinRst;
      cfg_r.view_y_min <= EdgeMinRst;
      cfg_r.view_x_max <= EdgeMaxRst;
      cfg_r.view_y_max <= EdgeMaxRst;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_WIN_X_MIN:  cfg_r.win_x_min  <= cfg_wdata;
        CFG_WIN_Y_MIN:  cfg_r.win_y_min  <= cfg_wdata;
        CFG_WIN_X_MAX:  cfg_r.win_x_max  <= cfg_wdata;
        CFG_WIN_Y_MAX:  cfg_r.win_y_max  <= cfg_wdata;
        CFG_VIEW_X_MIN: cfg_r.view_x_min <= cfg_wdata;
        CFG_VIEW_Y_MIN: cfg_r.view_y_min <= cfg_wdata;
        CFG_VIEW_X_MAX: cfg_r.view_x_max <= cfg_wdata;
        CFG_VIEW_Y_MAX: cfg_r.view_y_max <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lcvm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  lcvm_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  lcvm_back #(.PF(PARAM_FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_data    (qb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Rejected segments never carry coordinates.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.visible |->
      out_data.out_start_x == '0 && out_data.out_start_y == '0 &&
      out_data.out_end_x == '0 && out_data.out_end_y == '0)
    else $error("invisible segment with nonzero coordinates");

  // A visible result needs a window of positive size.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.visible |->
      cfg_r.win_x_max > cfg_r.win_x_min && cfg_r.win_y_max > cfg_r.win_y_min)
    else $error("visible segment from an empty window");

  // Reset leaves no result pending.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

### sv/lcvm_front.sv
// ---------------------------------------------------------------------------
// lcvm_front
// Accepts segments and sorts them into the left, right, bottom and top edge tests of the clipper.
// ---------------------------------------------------------------------------
module lcvm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lcvm_pkg::seg_in_t   in_data,
  input  lcvm_pkg::clip_cfg_t cfg,
  output logic                q_valid,
  input  logic                q_ready,
  output lcvm_pkg::seg_cls_t  q_data
);
  import lcvm_pkg::*;

  seg_cls_t                   front_r;
  seg_cls_t                   cls_nxt;
  logic                       front_vld_r;
  logic signed [DiffBits-1:0] x0e, y0e, x1e, y1e, dx, dy;
  logic signed [DiffBits-1:0] qv [NumEdges];
  logic [DiffBits-1:0]        dx_mag, dy_mag;
  logic                       dx_zero, dy_zero;

  function automatic logic [DiffBits-1:0] mag_of(input logic signed [DiffBits-1:0] v);
    return v[DiffBits-1] ? DiffBits'(-v) : DiffBits'(v);
  endfunction

  assign x0e = DiffBits'(in_data.start_x);
  assign y0e = DiffBits'(in_data.start_y);
  assign x1e = DiffBits'(in_data.end_x);
  assign y1e = DiffBits'(in_data.end_y);
  assign dx  = x1e - x0e;
  assign dy  = y1e - y0e;
  assign dx_mag  = mag_of(dx);
  assign dy_mag  = mag_of(dy);
  assign dx_zero = (dx == '0);
  assign dy_zero = (dy == '0);

  // Edges in the order left, right, bottom, top.
  assign qv[0] = x0e - DiffBits'(cfg.win_x_min);
  assign qv[1] = DiffBits'(cfg.win_x_max) - x0e;
  assign qv[2] = y0e - DiffBits'(cfg.win_y_min);
  assign qv[3] = DiffBits'(cfg.win_y_max) - y0e;

  always_comb begin
    cls_nxt.x0     = in_data.start_x;
    cls_nxt.y0     = in_data.start_y;
    cls_nxt.dx     = dx;
    cls_nxt.dy     = dy;
    cls_nxt.win_ok = (cfg.win_x_max > cfg.win_x_min) && (cfg.win_y_max > cfg.win_y_min);
    for (int e = 0; e < NumEdges; e++) begin
      cls_nxt.edges[e].qneg = qv[e][DiffBits-1];
      cls_nxt.edges[e].qmag = mag_of(qv[e]);
    end
    // Left and bottom use p = -d, right and top use p = d.
    cls_nxt.edges[0].pzero = dx_zero;
    cls_nxt.edges[0].pneg  = !dx[DiffBits-1] && !dx_zero;
    cls_nxt.edges[0].pmag  = dx_mag;
    cls_nxt.edges[1].pzero = dx_zero;
    cls_nxt.edges[1].pneg  = dx[DiffBits-1];
    cls_nxt.edges[1].pmag  = dx_mag;
    cls_nxt.edges[2].pzero = dy_zero;
    cls_nxt.edges[2].pneg  = !dy[DiffBits-1] && !dy_zero;
    cls_nxt.edges[2].pmag  = dy_mag;
    cls_nxt.edges[3].pzero = dy_zero;
    cls_nxt.edges[3].pneg  = dy[DiffBits-1];
    cls_nxt.edges[3].pmag  = dy_mag;
  end

  assign in_ready = !front_vld_r || q_ready;
  assign q_valid  = front_vld_r;
  assign q_data   = front_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_vld_r <= 1'b0;
    end else if (in_ready) begin
      front_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      front_r <= cls_nxt;
    end
  end

endmodule

### sv/lcvm_fifo.sv
// ---------------------------------------------------------------------------
// lcvm_fifo
// Short queue of classified segments between the front and the back end.
// ---------------------------------------------------------------------------
module lcvm_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  lcvm_pkg::seg_cls_t push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output lcvm_pkg::seg_cls_t pop_data
);
  import lcvm_pkg::*;

  seg_cls_t               mem_r [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QueuePtrW:0]     cnt_r;
  logic                   push, pop;

  assign push_ready = (cnt_r != (QueuePtrW+1)'(QueueDepth));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

### sv/lcvm_div.sv
// ---------------------------------------------------------------------------
// lcvm_div
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// flag for quotients that do not fit in QuoW bits.
// ---------------------------------------------------------------------------
module lcvm_div #(
  parameter int NumW = 8,
  parameter int DenW = 8,
  parameter int QuoW = 8
) (
  input  logic            clk,
  input  logic            en,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic [QuoW-1:0] quo,
  output logic            ovf
);
  localparam int SW = (NumW > DenW + QuoW) ? NumW : DenW + QuoW;

  logic [SW-1:0]   rem_r [QuoW];
  logic [DenW-1:0] den_r [QuoW];
  logic [QuoW-1:0] quo_r [QuoW+1];
  logic            ovf_r [QuoW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= SW'(num);
      den_r[0] <= den;
      quo_r[0] <= '0;
      ovf_r[0] <= SW'(num) >= (SW'(den) << QuoW);
    end
  end

  for (genvar k = 1; k <= QuoW; k++) begin : g_stage
    localparam int B = QuoW - k;
    logic [SW-1:0] trial;
    logic          take;
    assign trial = SW'(den_r[k-1]) << B;
    assign take  = rem_r[k-1] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k] <= take ? (quo_r[k-1] | (QuoW'(1) << B)) : quo_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
    end

    if (k < QuoW) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? rem_r[k-1] - trial : rem_r[k-1];
          den_r[k] <= den_r[k-1];
        end
      end
    end
  end

  assign quo = quo_r[QuoW];
  assign ovf = ovf_r[QuoW];

endmodule

### sv/lcvm_back.sv
// ---------------------------------------------------------------------------
// lcvm_back
// Edge parameter division, interval test, clip point and viewport mapping.
// The whole pipeline advances together whenever the output register is free.
// ---------------------------------------------------------------------------
module lcvm_back #(
  parameter int PF = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lcvm_pkg::clip_cfg_t cfg,
  input  logic                q_valid,
  output logic                q_ready,
  input  lcvm_pkg::seg_cls_t  q_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lcvm_pkg::seg_out_t  out_data
);
  import lcvm_pkg::*;

  localparam int CW  = CoordBits;
  localparam int DW  = DiffBits;
  localparam int TQW = PF + 1;
  localparam int TNW = DW + PF + 2;
  localparam int TDW = DW + 1;
  localparam int LT  = TQW + 1;
  localparam int TW  = PF + 2;
  localparam int CTW = CW + PF + 2;
  localparam int MW  = CW + PF + 1;
  localparam int VW  = CW + 1;
  localparam int PW  = MW + VW;
  localparam int MNW = PW + 2;
  localparam int MDW = CW + PF + 1;
  localparam int MQW = CW + 1;
  localparam int LM  = MQW + 1;
  localparam int RW  = CW + 2;

  localparam logic [TQW-1:0]       TSat   = TQW'((1 << PF) + 1);
  localparam logic signed [TW-1:0] TOne   = TW'(1 << PF);
  localparam logic [MQW-1:0]       MSat   = MQW'(1 << CW);
  localparam logic signed [RW-1:0] RMax   = RW'((1 << (CW - 1)) - 1);
  localparam logic signed [RW-1:0] RMin   = RW'(-(1 << (CW - 1)));

  logic adv;
  assign adv     = !out_valid || out_ready;
  assign q_ready = adv;

  // ---- edge parameter dividers ----
  logic [TQW-1:0] tq  [NumEdges];
  logic           tov [NumEdges];

  for (genvar e = 0; e < NumEdges; e++) begin : g_tdiv
    lcvm_div #(.NumW(TNW), .DenW(TDW), .QuoW(TQW)) u_div (
      .clk (clk),
      .en  (adv),
      .num ((TNW'(q_data.edges[e].qmag) << (PF + 1)) + TNW'(q_data.edges[e].pmag)),
      .den (TDW'(q_data.edges[e].pmag) << 1),
      .quo (tq[e]),
      .ovf (tov[e])
    );
  end

  seg_cls_t        tp_r [LT];
  logic [LT-1:0]   tv_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      tp_r[0] <= q_data;
      for (int i = 1; i < LT; i++) tp_r[i] <= tp_r[i-1];
    end
  end

  // ---- interval test ----
  seg_cls_t               tb;
  logic signed [TW-1:0]   te, tl, tv;
  logic [TQW-1:0]         tmag;
  logic                   vis_b;

  assign tb = tp_r[LT-1];

  // The parameters are clamped just past one: surviving te and tl always lie in
  // [0, 1], so every comparison keeps its outcome.
  always_comb begin
    te    = '0;
    tl    = TOne;
    vis_b = tb.win_ok;
    tmag  = '0;
    tv    = '0;
    for (int e = 0; e < NumEdges; e++) begin
      tmag = (tov[e] || tq[e] > TSat) ? TSat : tq[e];
      tv   = (tb.edges[e].qneg ^ tb.edges[e].pneg) ? -TW'(tmag) : TW'(tmag);
      if (tb.edges[e].pzero) begin
        if (tb.edges[e].qneg) vis_b = 1'b0;
      end else if (tb.edges[e].pneg) begin
        if (tv > te) te = tv;
        if (tv > tl) vis_b = 1'b0;
      end else begin
        if (tv < tl) tl = tv;
        if (tv < te) vis_b = 1'b0;
      end
    end
  end

  logic                       b_vld_r, b_vis_r;
  logic [TQW-1:0]             b_te_r, b_tl_r;
  coord_t                     b_x0_r, b_y0_r;
  logic signed [DW-1:0]       b_dx_r, b_dy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      b_vis_r <= vis_b;
      b_te_r  <= TQW'(te);
      b_tl_r  <= TQW'(tl);
      b_x0_r  <= tb.x0;
      b_y0_r  <= tb.y0;
      b_dx_r  <= tb.dx;
      b_dy_r  <= tb.dy;
    end
  end

  // ---- clip points: start x, start y, end x, end y ----
  logic signed [CTW-1:0] c_r [NumPoints];
  logic                  c_vld_r, c_vis_r;

  for (genvar k = 0; k < NumPoints; k++) begin : g_clip
    logic signed [PF+1:0]    ts;
    logic signed [DW-1:0]    dk;
    coord_t                  bk;
    logic signed [PF+DW+1:0] prod;
    assign ts   = (k < 2) ? $signed({1'b0, b_te_r}) : $signed({1'b0, b_tl_r});
    assign dk   = (k % 2 == 0) ? b_dx_r : b_dy_r;
    assign bk   = (k % 2 == 0) ? b_x0_r : b_y0_r;
    assign prod = ts * dk;
    always_ff @(posedge clk) begin
      if (adv) c_r[k] <= (CTW'(bk) <<< PF) + CTW'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) c_vis_r <= b_vis_r;
  end

  // ---- offset into the window and viewport span ----
  logic signed [VW-1:0] vsx, vsy;
  logic [VW-1:0]        vmx, vmy;
  assign vsx = VW'(cfg.view_x_max) - VW'(cfg.view_x_min);
  assign vsy = VW'(cfg.view_y_max) - VW'(cfg.view_y_min);
  assign vmx = vsx[VW-1] ? VW'(-vsx) : VW'(vsx);
  assign vmy = vsy[VW-1] ? VW'(-vsy) : VW'(vsy);

  logic [MW-1:0] d_mag_r [NumPoints];
  logic          d_neg_r [NumPoints];
  logic          d_vld_r, d_vis_r;

  for (genvar k = 0; k < NumPoints; k++) begin : g_diff
    logic signed [CTW-1:0] diff;
    coord_t                wmin;
    assign wmin = (k % 2 == 0) ? cfg.win_x_min : cfg.win_y_min;
    assign diff = c_r[k] - (CTW'(wmin) <<< PF);
    always_ff @(posedge clk) begin
      if (adv) begin
        d_mag_r[k] <= diff[CTW-1] ? MW'(-diff) : MW'(diff);
        d_neg_r[k] <= diff[CTW-1] ^ ((k % 2 == 0) ? vsx[VW-1] : vsy[VW-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) d_vis_r <= c_vis_r;
  end

  // ---- scale product ----
  logic [PW-1:0] e_prod_r [NumPoints];
  logic          e_neg_r  [NumPoints];
  logic          e_vld_r, e_vis_r;

  for (genvar k = 0; k < NumPoints; k++) begin : g_scale
    always_ff @(posedge clk) begin
      if (adv) begin
        e_prod_r[k] <= PW'(d_mag_r[k]) * PW'((k % 2 == 0) ? vmx : vmy);
        e_neg_r[k]  <= d_neg_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) e_vis_r <= d_vis_r;
  end

  // ---- division by the window span ----
  logic signed [DW-1:0] wdx, wdy;
  logic [CW+PF-1:0]     wsx, wsy;
  assign wdx = DW'(cfg.win_x_max) - DW'(cfg.win_x_min);
  assign wdy = DW'(cfg.win_y_max) - DW'(cfg.win_y_min);
  assign wsx = {wdx[CW-1:0], PF'(0)};
  assign wsy = {wdy[CW-1:0], PF'(0)};

  logic [MQW-1:0] mq  [NumPoints];
  logic           mov [NumPoints];

  for (genvar k = 0; k < NumPoints; k++) begin : g_mdiv
    logic [CW+PF-1:0] ws;
    assign ws = (k % 2 == 0) ? wsx : wsy;
    lcvm_div #(.NumW(MNW), .DenW(MDW), .QuoW(MQW)) u_div (
      .clk (clk),
      .en  (adv),
      .num ((MNW'(e_prod_r[k]) << 1) + MNW'(ws)),
      .den ({ws, 1'b0}),
      .quo (mq[k]),
      .ovf (mov[k])
    );
  end

  logic [NumPoints-1:0] mneg_r [LM];
  logic [LM-1:0]        mvis_r;
  logic [LM-1:0]        mv_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      mneg_r[0] <= {e_neg_r[3], e_neg_r[2], e_neg_r[1], e_neg_r[0]};
      for (int i = 1; i < LM; i++) mneg_r[i] <= mneg_r[i-1];
      mvis_r <= {mvis_r[LM-2:0], e_vis_r};
    end
  end

  // ---- offset into the viewport, rounding is done, saturate ----
  coord_t res [NumPoints];

  for (genvar k = 0; k < NumPoints; k++) begin : g_sat
    logic [MQW-1:0]       qm;
    logic signed [RW-1:0] r;
    coord_t               vmin;
    assign vmin = (k % 2 == 0) ? cfg.view_x_min : cfg.view_y_min;
    assign qm   = (mov[k] || mq[k] > MSat) ? MSat : mq[k];
    assign r    = mneg_r[LM-1][k] ? RW'(vmin) - $signed(RW'(qm))
                                  : RW'(vmin) + $signed(RW'(qm));
    assign res[k] = (r > RMax) ? CW'(RMax) : (r < RMin) ? CW'(RMin) : CW'(r);
  end

  logic     out_vld_r;
  seg_out_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r      <= '0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      d_vld_r   <= 1'b0;
      e_vld_r   <= 1'b0;
      mv_r      <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      tv_r      <= {tv_r[LT-2:0], q_valid};
      b_vld_r   <= tv_r[LT-1];
      c_vld_r   <= b_vld_r;
      d_vld_r   <= c_vld_r;
      e_vld_r   <= d_vld_r;
      mv_r      <= {mv_r[LM-2:0], e_vld_r};
      out_vld_r <= mv_r[LM-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.visible     <= mvis_r[LM-1];
      out_r.out_start_x <= mvis_r[LM-1] ? res[0] : '0;
      out_r.out_start_y <= mvis_r[LM-1] ? res[1] : '0;
      out_r.out_end_x   <= mvis_r[LM-1] ? res[2] : '0;
      out_r.out_end_y   <= mvis_r[LM-1] ? res[3] : '0;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
